FILE: design/kwl_pkg.sv
// Shared types, token kind codes and keyword table for the keyword lexer.
// No dependencies; every other design file imports this package.
package kwl_pkg;

    localparam int POS_BITS   = 32;
    localparam int LEN_BITS   = 16;
    localparam int KW_COUNT   = 12;
    localparam int KW_MAX_LEN = 5;
    localparam int PREFIX_W   = 8 * KW_MAX_LEN;
    localparam int START_W    = 32;
    localparam int LENGTH_W   = 16;
    localparam int VALUE_W    = 64;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    typedef logic [4:0] kind_t;

    localparam kind_t KIND_IDENT  = 5'd12;
    localparam kind_t KIND_INT    = 5'd13;
    localparam kind_t KIND_EQ     = 5'd14;
    localparam kind_t KIND_LPAREN = 5'd15;
    localparam kind_t KIND_RPAREN = 5'd16;
    localparam kind_t KIND_SEMI   = 5'd17;
    localparam kind_t KIND_END    = 5'd18;
    localparam kind_t KIND_ERROR  = 5'd19;

    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_NUM  = 2'd2,
        MODE_ERR  = 2'd3
    } mode_t;

    // keyword text, right aligned, in token kind order
    localparam logic [PREFIX_W-1:0] KW_TEXT [KW_COUNT] = '{
        40'h0065786974, 40'h0000007538, 40'h0000753136, 40'h0000753332,
        40'h0000753634, 40'h0000006938, 40'h0000693136, 40'h0000693332,
        40'h0000693634, 40'h0000663332, 40'h0000663634, 40'h7573697A65
    };
    localparam int KW_LEN [KW_COUNT] = '{4, 2, 3, 3, 3, 2, 3, 3, 3, 3, 3, 5};

    typedef struct packed {
        kind_t                kind;
        logic [START_W-1:0]   start_pos;
        logic [LENGTH_W-1:0]  length;
        logic [VALUE_W-1:0]   value;
        logic                 overflow;
        logic [7:0]           bad_char;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic kind_t word_kind(input logic [PREFIX_W-1:0] prefix,
                                        input logic [LEN_BITS-1:0] len);
        kind_t k;
        k = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len == LEN_BITS'(KW_LEN[i]) && prefix == KW_TEXT[i]) begin
                k = kind_t'(i);
            end
        end
        return k;
    endfunction

endpackage

FILE: design/kwl_core.sv
// Input beat register, lexer state and single-pass token logic.
// Depends on kwl_pkg; feeds up to two results per beat to kwl_out_fifo.
module kwl_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_cmd,
    input  logic [7:0]       s_ch,
    input  logic             room,
    output kwl_pkg::push_t   push
);
    import kwl_pkg::*;

    logic                item_vld_reg, item_vld_next;
    logic                item_cmd_reg;
    logic [7:0]          item_ch_reg;
    mode_t               mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [PREFIX_W-1:0] prefix_reg, prefix_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic                ovf_reg, ovf_next;

    logic                proc;
    logic                is_alpha, is_digit, is_space, open_tok, extend;
    logic [VALUE_W+3:0]  acc_wide;
    logic [LEN_BITS-1:0] len_grown;
    result_t             close_res, start_res;
    logic                start_vld;

    assign s_ready       = !item_vld_reg || room;
    assign proc          = item_vld_reg && room;
    assign item_vld_next = (s_valid && s_ready) || (item_vld_reg && !proc);

    assign is_alpha = item_ch_reg inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    assign is_digit = item_ch_reg inside {[8'h30:8'h39]};
    assign is_space = item_ch_reg inside {8'h20, [8'h09:8'h0D]};
    assign open_tok = (mode_reg == MODE_WORD) || (mode_reg == MODE_NUM);
    assign extend   = ((mode_reg == MODE_WORD) && (is_alpha || is_digit))
                   || ((mode_reg == MODE_NUM) && is_digit);

    assign acc_wide  = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                     + (VALUE_W+4)'(item_ch_reg - CH_ZERO);
    assign len_grown = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;

    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        if (proc) begin
            if (item_cmd_reg) begin
                mode_next   = MODE_IDLE;
                pos_next    = '0;
                start_next  = '0;
                len_next    = '0;
                prefix_next = '0;
                acc_next    = '0;
                ovf_next    = 1'b0;
            end else begin
                pos_next = pos_reg + 1'b1;
                if (mode_reg == MODE_ERR) begin
                    mode_next = MODE_ERR;
                end else if (extend) begin
                    len_next = len_grown;
                    if (mode_reg == MODE_WORD) begin
                        if (len_reg < LEN_BITS'(KW_MAX_LEN)) begin
                            prefix_next = {prefix_reg[PREFIX_W-9:0], item_ch_reg};
                        end
                    end else if (acc_wide[VALUE_W+3:VALUE_W] != '0) begin
                        acc_next = '1;
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = acc_wide[VALUE_W-1:0];
                    end
                end else begin
                    start_next  = pos_reg;
                    len_next    = LEN_BITS'(1);
                    prefix_next = '0;
                    acc_next    = '0;
                    ovf_next    = 1'b0;
                    if (is_alpha) begin
                        mode_next   = MODE_WORD;
                        prefix_next = PREFIX_W'(item_ch_reg);
                    end else if (is_digit) begin
                        mode_next = MODE_NUM;
                        acc_next  = VALUE_W'(item_ch_reg - CH_ZERO);
                    end else if (is_space || item_ch_reg == CH_EQ
                              || item_ch_reg == CH_LPAREN || item_ch_reg == CH_RPAREN
                              || item_ch_reg == CH_SEMI) begin
                        mode_next = MODE_IDLE;
                    end else begin
                        mode_next = MODE_ERR;
                    end
                end
            end
        end
    end

    always_comb begin
        close_res           = '0;
        close_res.kind      = (mode_reg == MODE_WORD) ? word_kind(prefix_reg, len_reg)
                                                      : KIND_INT;
        close_res.start_pos = START_W'(start_reg);
        close_res.length    = LENGTH_W'(len_reg);
        if (mode_reg == MODE_NUM) begin
            close_res.value    = acc_reg;
            close_res.overflow = ovf_reg;
        end

        start_res           = '0;
        start_res.start_pos = START_W'(pos_reg);
        start_res.length    = LENGTH_W'(1);
        start_res.last      = 1'b1;
        start_vld           = 1'b1;
        if (item_cmd_reg) begin
            start_res.kind   = KIND_END;
            start_res.length = '0;
        end else if (item_ch_reg == CH_EQ) begin
            start_res.kind = KIND_EQ;
        end else if (item_ch_reg == CH_LPAREN) begin
            start_res.kind = KIND_LPAREN;
        end else if (item_ch_reg == CH_RPAREN) begin
            start_res.kind = KIND_RPAREN;
        end else if (item_ch_reg == CH_SEMI) begin
            start_res.kind = KIND_SEMI;
        end else begin
            start_res.kind     = KIND_ERROR;
            start_res.bad_char = item_ch_reg;
            start_vld          = !(is_alpha || is_digit || is_space);
        end

        push = '0;
        if (proc) begin
            if (item_cmd_reg) begin
                if (open_tok) begin
                    push.count = 2'd2;
                    push.first = close_res;
                    push.second = start_res;
                end else begin
                    push.count = 2'd1;
                    push.first = start_res;
                end
            end else if (mode_reg != MODE_ERR && !extend) begin
                if (open_tok && start_vld) begin
                    push.count  = 2'd2;
                    push.first  = close_res;
                    push.second = start_res;
                end else if (open_tok) begin
                    push.count      = 2'd1;
                    push.first      = close_res;
                    push.first.last = 1'b1;
                end else if (start_vld) begin
                    push.count = 2'd1;
                    push.first = start_res;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            pos_reg      <= '0;
            start_reg    <= '0;
            len_reg      <= '0;
            prefix_reg   <= '0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            item_vld_reg <= item_vld_next;
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            len_reg      <= len_next;
            prefix_reg   <= prefix_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_cmd_reg <= s_cmd;
            item_ch_reg  <= s_ch;
        end
    end

endmodule

FILE: design/kwl_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one beat a cycle
// while m_ready is high. Depends on kwl_pkg.
module kwl_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  kwl_pkg::push_t    push,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output kwl_pkg::result_t  m_data
);
    import kwl_pkg::*;

    result_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    assign m_valid     = count_reg != '0;
    assign m_data      = mem[rd_ptr_reg];
    assign room        = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign pop         = m_valid && m_ready;
    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + 1'b1] <= push.second;
        end
    end

endmodule

FILE: design/keyword_lexer.sv
// keyword_lexer: one source byte or end marker per beat, tokens out.
// Input beat is registered, its results then queued; a beat may give two.
// Throughput: one input beat per cycle while the 4-entry result queue has room
// for two results; one result beat out per cycle while m_axis_tready is high.
// Reset: aresetn synchronous active low; clears lexer state, position and queue.
// Depends on kwl_pkg, kwl_core, kwl_out_fifo.
module keyword_lexer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // ch
    input  logic         s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // start_pos, token_length, int_value,
                                         // value_overflow, bad_char, zero pad
    output logic [4:0]   m_axis_tuser,   // token_kind
    output logic         m_axis_tlast    // last_in_run
);
    import kwl_pkg::*;

    push_t   push;
    logic    room;
    result_t out_res;

    kwl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_cmd   (s_axis_tuser),
        .s_ch    (s_axis_tdata),
        .room    (room),
        .push    (push)
    );

    kwl_out_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (out_res)
    );

    assign m_axis_tdata = {7'b0, out_res.bad_char, out_res.overflow, out_res.value,
                           out_res.length, out_res.start_pos};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

`ifndef SYNTHESIS
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tlast)
        else $error("end token not last in run");

    a_value_int_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != KIND_INT |-> m_axis_tdata[112:48] == '0)
        else $error("value or overflow set on non-integer token");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> $past(room) || room)
        else $error("result pushed without queue room");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result beat valid after reset");
`endif

endmodule

FILE: tb/keyword_lexer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyword_lexer: random and directed source text
// in, every token compared field by field against an in-bench tokenizer.
// Depends on kwl_pkg and the keyword_lexer RTL.
module keyword_lexer_tb;
    import kwl_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int CALM_FROM   = 500;
    localparam int CALM_TO     = 800;
    localparam int RAND_BEATS  = 1250;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct {
        logic       cmd;
        logic [7:0] ch;
    } src_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;
    logic         s_axis_tuser = CMD_CHAR;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;   // start_pos, token_length, int_value,
                                  // value_overflow, bad_char, zero pad
    logic [4:0]   m_axis_tuser;   // token_kind
    logic         m_axis_tlast;   // last_in_run

    keyword_lexer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    string kw_words [KW_COUNT] = '{"exit", "u8", "u16", "u32", "u64", "i8",
                                   "i16", "i32", "i64", "f32", "f64", "usize"};

    src_beat_t src_q [$];
    result_t   token_q [$];
    result_t   step_toks [$];

    // tokenizer state
    mode_t                lex_mode = MODE_IDLE;
    logic [POS_BITS-1:0]  pos_cnt = '0;
    logic [POS_BITS-1:0]  tok_start = '0;
    logic [LEN_BITS-1:0]  tok_len = '0;
    logic [PREFIX_W-1:0]  prefix = '0;
    logic [VALUE_W-1:0]   acc = '0;
    logic                 acc_ovf = 1'b0;

    int beats_in = 0;
    int tokens_out = 0;
    int kw_seen = 0;
    int lit_seen = 0;
    int err_seen = 0;
    int err_cnt = 0;
    int stall_cnt = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic result_t make_tok(kind_t k, logic [POS_BITS-1:0] s,
                                         logic [LEN_BITS-1:0] n, logic [63:0] v,
                                         logic o, logic [7:0] b);
        result_t t;
        t.kind      = k;
        t.start_pos = s;
        t.length    = n;
        t.value     = v;
        t.overflow  = o;
        t.bad_char  = b;
        t.last      = 1'b0;
        return t;
    endfunction

    function automatic void add_tok(result_t t);
        step_toks.insert(step_toks.size(), t);
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic kind_t classify_word();
        kind_t                k;
        logic [PREFIX_W-1:0]  packed_kw;
        k = KIND_IDENT;
        if (tok_len <= KW_MAX_LEN) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                packed_kw = '0;
                for (int j = 0; j < kw_words[i].len(); j++) begin
                    packed_kw = {packed_kw[PREFIX_W-9:0], kw_words[i][j]};
                end
                if (kw_words[i].len() == tok_len && packed_kw == prefix) begin
                    k = kind_t'(i);
                end
            end
        end
        return k;
    endfunction

    function automatic void close_token();
        if (lex_mode == MODE_WORD) begin
            add_tok(make_tok(classify_word(), tok_start, tok_len, '0, 1'b0, '0));
        end else if (lex_mode == MODE_NUM) begin
            add_tok(make_tok(KIND_INT, tok_start, tok_len, acc, acc_ovf, '0));
        end
        lex_mode = MODE_IDLE;
    endfunction

    function automatic void open_token(logic [7:0] c, logic [POS_BITS-1:0] here);
        tok_start = here;
        tok_len   = LEN_BITS'(1);
        prefix    = '0;
        acc       = '0;
        acc_ovf   = 1'b0;
        if (is_letter(c)) begin
            lex_mode = MODE_WORD;
            prefix   = PREFIX_W'(c);
        end else if (is_num(c)) begin
            lex_mode = MODE_NUM;
            acc      = VALUE_W'(c - CH_ZERO);
        end else if (c == CH_EQ) begin
            add_tok(make_tok(KIND_EQ, here, LEN_BITS'(1), '0, 1'b0, '0));
        end else if (c == CH_LPAREN) begin
            add_tok(make_tok(KIND_LPAREN, here, LEN_BITS'(1), '0, 1'b0, '0));
        end else if (c == CH_RPAREN) begin
            add_tok(make_tok(KIND_RPAREN, here, LEN_BITS'(1), '0, 1'b0, '0));
        end else if (c == CH_SEMI) begin
            add_tok(make_tok(KIND_SEMI, here, LEN_BITS'(1), '0, 1'b0, '0));
        end else if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
            add_tok(make_tok(KIND_ERROR, here, LEN_BITS'(1), '0, 1'b0, c));
            lex_mode = MODE_ERR;
        end
    endfunction

    // advance the tokenizer by one beat and queue the tokens it yields
    function automatic void lex_step(logic cmd, logic [7:0] c);
        logic [POS_BITS-1:0] here;
        logic [63:0]         d;
        here = pos_cnt;
        step_toks.delete();
        if (cmd == CMD_END) begin
            if (lex_mode != MODE_ERR) close_token();
            add_tok(make_tok(KIND_END, here, '0, '0, 1'b0, '0));
            lex_mode  = MODE_IDLE;
            pos_cnt   = '0;
            tok_start = '0;
            tok_len   = '0;
            prefix    = '0;
            acc       = '0;
            acc_ovf   = 1'b0;
        end else begin
            pos_cnt = pos_cnt + 1'b1;
            if (lex_mode == MODE_ERR) begin
            end else if (lex_mode == MODE_WORD && (is_letter(c) || is_num(c))) begin
                if (tok_len < KW_MAX_LEN) prefix = {prefix[PREFIX_W-9:0], c};
                if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
            end else if (lex_mode == MODE_NUM && is_num(c)) begin
                d = 64'(c - CH_ZERO);
                if (acc > ({VALUE_W{1'b1}} - d) / 10) begin
                    acc     = {VALUE_W{1'b1}};
                    acc_ovf = 1'b1;
                end else begin
                    acc = acc * 10 + d;
                end
                if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
            end else begin
                close_token();
                open_token(c, here);
            end
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) token_q.insert(token_q.size(), step_toks[i]);
    endfunction

    function automatic bit idle_roll(int n);
        if (n >= CALM_FROM && n < CALM_TO) return 1'b0;
        return $urandom_range(99) < 29;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH token %0d %s: got %0h want %0h", tokens_out, what, got, want);
        err_cnt++;
    endtask

    task automatic put_byte(logic [7:0] c);
        src_beat_t b;
        b.cmd = CMD_CHAR;
        b.ch  = c;
        src_q.insert(src_q.size(), b);
    endtask

    task automatic put_end();
        src_beat_t b;
        b.cmd = CMD_END;
        b.ch  = 8'($urandom_range(255));
        src_q.insert(src_q.size(), b);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'(65 + $urandom_range(25)) : 8'(97 + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_space();
        logic [7:0] ws [6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
        return ws[$urandom_range(5)];
    endfunction

    task automatic build_random();
        int    sel;
        int    n;
        string punct;
        punct = "=();";
        while (src_q.size() < RAND_BEATS) begin
            sel = $urandom_range(99);
            if (sel < 26) begin
                put_text(kw_words[$urandom_range(KW_COUNT - 1)]);
                if ($urandom_range(9) < 7) put_byte(rand_space());
            end else if (sel < 40) begin
                put_byte(rand_letter());
                n = $urandom_range(7);
                repeat (n) put_byte($urandom_range(3) == 0 ? 8'(48 + $urandom_range(9))
                                                           : rand_letter());
                if ($urandom_range(9) < 7) put_byte(rand_space());
            end else if (sel < 55) begin
                n = ($urandom_range(4) == 0) ? $urandom_range(19, 24) : $urandom_range(1, 6);
                repeat (n) put_byte(8'(48 + $urandom_range(9)));
                if ($urandom_range(9) < 7) put_byte(rand_space());
            end else if (sel < 70) begin
                put_byte(punct[$urandom_range(3)]);
            end else if (sel < 86) begin
                repeat ($urandom_range(1, 3)) put_byte(rand_space());
            end else if (sel < 93) begin
                put_end();
            end else if (sel < 95) begin
                put_byte(8'($urandom_range(255)));
            end else begin
                // near misses: keyword plus one char, or a keyword cut short
                n = $urandom_range(KW_COUNT - 1);
                if ($urandom_range(1)) begin
                    put_text(kw_words[n]);
                    put_byte(rand_letter());
                end else begin
                    put_text(kw_words[n].substr(0, kw_words[n].len() - 2));
                end
                put_byte(rand_space());
            end
        end
        put_end();
    endtask

    always @(posedge aclk) begin : drive_source
        src_beat_t b;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                lex_step(s_axis_tuser, s_axis_tdata);
                beats_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_q.size() > 0 && !idle_roll(beats_in)) begin
                    b = src_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= b.ch;
                    s_axis_tuser  <= b.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_tokens
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind      = m_axis_tuser;
                got.start_pos = m_axis_tdata[31:0];
                got.length    = m_axis_tdata[47:32];
                got.value     = m_axis_tdata[111:48];
                got.overflow  = m_axis_tdata[112];
                got.bad_char  = m_axis_tdata[120:113];
                got.last      = m_axis_tlast;
                if (got.kind < KIND_IDENT) kw_seen++;
                if (got.kind == KIND_INT) lit_seen++;
                if (got.kind == KIND_ERROR) err_seen++;
                if (token_q.size() == 0) begin
                    flag_mismatch("with none pending, kind", 64'(got.kind), '0);
                end else begin
                    want = token_q.pop_front();
                    if (got.kind != want.kind)
                        flag_mismatch("kind", 64'(got.kind), 64'(want.kind));
                    if (got.start_pos != want.start_pos)
                        flag_mismatch("start_pos", 64'(got.start_pos), 64'(want.start_pos));
                    if (got.length != want.length)
                        flag_mismatch("length", 64'(got.length), 64'(want.length));
                    if (got.value != want.value) flag_mismatch("value", got.value, want.value);
                    if (got.overflow != want.overflow)
                        flag_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
                    if (got.bad_char != want.bad_char)
                        flag_mismatch("bad_char", 64'(got.bad_char), 64'(want.bad_char));
                    if (got.last != want.last)
                        flag_mismatch("last", 64'(got.last), 64'(want.last));
                end
                tokens_out++;
            end
            m_axis_tready <= !idle_roll(tokens_out);
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cnt <= 0;
            end else if (stall_cnt >= STALL_LIMIT) begin
                $display("TIMEOUT: no beat moved in %0d cycles, %0d tokens pending",
                         STALL_LIMIT, token_q.size());
                $display("keyword_lexer_tb: done, errors");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    initial begin
        // directed: keywords next to punctuation, a six-letter word, an
        // unknown byte with input ignored after it, an open number at the end
        put_text("usize(u8)=7;");
        put_end();
        put_text("usizes i64");
        put_byte(8'hFF);
        put_text("a;");
        put_end();
        put_text("f32 9");
        put_end();
        // largest value, then one past it, then far past it
        put_text("18446744073709551615;18446744073709551616 99999999999999999999999");
        put_end();
        build_random();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (src_q.size() > 0 || s_axis_tvalid) @(posedge aclk);
        while (token_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Lexed %0d source beats into %0d tokens: %0d keywords, %0d int literals,",
                 beats_in, tokens_out, kw_seen, lit_seen);
        $display("%0d error tokens, with saturated values and stalls on both sides.",
                 err_seen);
        if (err_cnt == 0) begin
            $display("keyword_lexer_tb: done, clean");
        end else begin
            $display("keyword_lexer_tb: done, errors");
        end
        $finish;
    end

endmodule
